>>> rtl/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// nrmc_pkg: shared types and constants of the GPRMC position parser
// Character codes, field indexes, fixed-point scaling and the records that
// pass between the byte parser, the top level and the coordinate converters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nrmc_pkg;

  // ASCII codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_FIX    = 8'h41;  // 'A'
  localparam logic [7:0] CH_SOUTH  = 8'h53;  // 'S'
  localparam logic [7:0] CH_WEST   = 8'h57;  // 'W'

  // Field indexes within the sentence
  localparam logic [3:0] FLD_TYPE   = 4'd0;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_NS     = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_EW     = 4'd6;

  localparam logic [3:0] TYPE_LEN    = 4'd5;  // "GPRMC"
  localparam logic [3:0] LAT_DEG_LEN = 4'd2;
  localparam logic [3:0] LON_DEG_LEN = 4'd3;
  localparam logic [3:0] CKS_LEN     = 4'd2;

  // Minutes are kept as minutes * 10^MIN_FRAC_DIGITS
  localparam int MIN_FRAC_DIGITS = 5;
  localparam int MIN_W           = 24;
  localparam logic [MIN_W-1:0] MIN_SAT = {MIN_W{1'b1}};

  localparam int LAT_DEG_W = 7;
  localparam int LON_DEG_W = 10;
  localparam int LAT_W     = 31;
  localparam int LON_W     = 32;
  localparam int unsigned LAT_LIMIT = 900000000;
  localparam int unsigned LON_LIMIT = 1800000000;

  // mag = deg*1e7 + floor((m*1e7 + 30P) / (60P)), P = 10^F.
  // Dividing out G = gcd(1e7, 60P) leaves floor((2*m*A_MUL + C_DIV) / DIV_D)
  // with DIV_D = 2*C_DIV = 3 * 2^DIV_K.
  localparam int P_SCALE  = 10 ** MIN_FRAC_DIGITS;
  localparam int GCD_E2   = (MIN_FRAC_DIGITS + 2 < 7) ? MIN_FRAC_DIGITS + 2 : 7;
  localparam int GCD_F    = (2 ** GCD_E2) * (5 ** (MIN_FRAC_DIGITS + 1));
  localparam int A_MUL    = 10000000 / GCD_F;
  localparam int C_DIV    = 60 * P_SCALE / GCD_F;
  localparam int DIV_D    = 2 * C_DIV;
  localparam int DIV_K    = $clog2(DIV_D / 3);
  localparam int A_MUL_W  = 16;
  localparam int X_W      = MIN_W + A_MUL_W + 1;

  localparam int DEG_SCALE_W = 24;
  localparam logic [DEG_SCALE_W-1:0] DEG_SCALE = 24'd10000000;

  // Exact divide by three for values below 2^Y_W
  localparam int Y_W         = 33;
  localparam int RECIP_W     = 34;
  localparam int RECIP_HW    = RECIP_W / 2;
  localparam int RECIP_SHIFT = 35;
  localparam logic [RECIP_W-1:0] DIV3_RECIP = 34'd11453246123;
  localparam int Q_W         = 32;

  typedef struct packed {
    logic fix;
    logic cks_ok;
  } flags_t;

  typedef struct packed {
    logic [LAT_DEG_W-1:0] lat_deg;
    logic [MIN_W-1:0]     lat_min;
    logic                 south;
    logic [LON_DEG_W-1:0] lon_deg;
    logic [MIN_W-1:0]     lon_min;
    logic                 west;
    flags_t               flags;
  } snap_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  typedef struct packed {
    logic [2:0]       fds;
    logic [MIN_W-1:0] acc;
  } min_upd_t;

  function automatic logic [19:0] pow10(input logic [2:0] e);
    logic [19:0] r;
    case (e)
      3'd0:    r = 20'd1;
      3'd1:    r = 20'd10;
      3'd2:    r = 20'd100;
      3'd3:    r = 20'd1000;
      3'd4:    r = 20'd10000;
      3'd5:    r = 20'd100000;
      3'd6:    r = 20'd1000000;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/nrmc_parser.sv
// ----------------------------------------------------------------------------
// nrmc_parser: byte-level sentence parser
// Field splitting, type check, digit accumulation, flags and checksum.
// Raises emit_o with a snapshot of the sentence on the terminating CR.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrmc_parser import nrmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  output logic       emit_o,
  output snap_t      snap_o
);

  logic                 in_sent_q, in_sent_d;
  logic                 type_ok_q, type_ok_d;
  logic [3:0]           field_q, field_d;
  logic [3:0]           pos_q, pos_d;
  logic [LAT_DEG_W-1:0] lat_deg_q, lat_deg_d;
  logic [MIN_W-1:0]     lat_min_q, lat_min_d;
  logic [LON_DEG_W-1:0] lon_deg_q, lon_deg_d;
  logic [MIN_W-1:0]     lon_min_q, lon_min_d;
  logic [2:0]           fds_q, fds_d;
  logic                 south_q, south_d;
  logic                 west_q, west_d;
  logic                 fix_q, fix_d;
  logic [7:0]           xor_q, xor_d;
  logic [7:0]           rsum_q, rsum_d;
  logic                 star_q, star_d;

  logic       is_digit;
  logic [4:0] hex;
  min_upd_t   mupd;

  function automatic logic [3:0] sat_inc(input logic [3:0] v);
    return (v == 4'hF) ? v : v + 4'd1;
  endfunction

  function automatic logic [7:0] type_char(input logic [2:0] p);
    logic [7:0] r;
    case (p)
      3'd0:    r = "G";
      3'd1:    r = "P";
      3'd2:    r = "R";
      3'd3:    r = "M";
      3'd4:    r = "C";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

  function automatic min_upd_t min_add(input logic [MIN_W-1:0] acc, input logic [2:0] fds,
                                       input logic [7:0] c);
    min_upd_t    r;
    logic [28:0] v;
    logic [3:0]  d;
    r.acc = acc;
    r.fds = fds;
    d     = c[3:0];
    v     = 29'(acc);
    if (c == CH_DOT) begin
      if (fds == 3'd0) r.fds = 3'd1;
    end else if (c >= CH_0 && c <= CH_9) begin
      if (fds == 3'd0) begin
        v = 29'(acc) * 29'd10 + 29'(d) * 29'(pow10(3'(MIN_FRAC_DIGITS)));
      end else if (fds <= 3'(MIN_FRAC_DIGITS)) begin
        v     = 29'(acc) + 29'(d) * 29'(pow10(3'(MIN_FRAC_DIGITS) - fds));
        r.fds = fds + 3'd1;
      end
      r.acc = (v > 29'(MIN_SAT)) ? MIN_SAT : v[MIN_W-1:0];
    end
    return r;
  endfunction

  assign is_digit = (byte_i >= CH_0) && (byte_i <= CH_9);
  assign hex      = hex_dec(byte_i);
  assign mupd     = min_add((field_q == FLD_LON) ? lon_min_q : lat_min_q, fds_q, byte_i);

  always_comb begin
    in_sent_d = in_sent_q;
    type_ok_d = type_ok_q;
    field_d   = field_q;
    pos_d     = pos_q;
    lat_deg_d = lat_deg_q;
    lat_min_d = lat_min_q;
    lon_deg_d = lon_deg_q;
    lon_min_d = lon_min_q;
    fds_d     = fds_q;
    south_d   = south_q;
    west_d    = west_q;
    fix_d     = fix_q;
    xor_d     = xor_q;
    rsum_d    = rsum_q;
    star_d    = star_q;
    if (accept_i) begin
      if (byte_i == CH_DOLLAR) begin
        in_sent_d = 1'b1;
        type_ok_d = 1'b1;
        field_d   = '0;
        pos_d     = '0;
        lat_deg_d = '0;
        lat_min_d = '0;
        lon_deg_d = '0;
        lon_min_d = '0;
        fds_d     = '0;
        south_d   = 1'b0;
        west_d    = 1'b0;
        fix_d     = 1'b0;
        xor_d     = '0;
        rsum_d    = '0;
        star_d    = 1'b0;
      end else if (in_sent_q) begin
        if (byte_i == CH_CR) begin
          in_sent_d = 1'b0;
        end else if (star_q) begin
          if (!hex[4]) begin
            pos_d = 4'hF;
          end else begin
            rsum_d = {rsum_q[3:0], hex[3:0]};
            pos_d  = sat_inc(pos_q);
          end
        end else if (byte_i == CH_STAR) begin
          star_d = 1'b1;
          pos_d  = '0;
          rsum_d = '0;
        end else begin
          xor_d = xor_q ^ byte_i;
          if (byte_i == CH_COMMA) begin
            if (field_q == FLD_TYPE && pos_q != TYPE_LEN) type_ok_d = 1'b0;
            field_d = sat_inc(field_q);
            pos_d   = '0;
            fds_d   = '0;
          end else begin
            case (field_q)
              FLD_TYPE: begin
                if (pos_q >= TYPE_LEN || byte_i != type_char(pos_q[2:0])) type_ok_d = 1'b0;
              end
              FLD_STATUS: begin
                fix_d = (pos_q == 4'd0) && (byte_i == CH_FIX);
              end
              FLD_LAT: begin
                if (pos_q < LAT_DEG_LEN) begin
                  if (is_digit) lat_deg_d = LAT_DEG_W'(lat_deg_q * 4'd10 + byte_i[3:0]);
                end else begin
                  lat_min_d = mupd.acc;
                  fds_d     = mupd.fds;
                end
              end
              FLD_NS: begin
                south_d = (pos_q == 4'd0) && (byte_i == CH_SOUTH);
              end
              FLD_LON: begin
                if (pos_q < LON_DEG_LEN) begin
                  if (is_digit) lon_deg_d = LON_DEG_W'(lon_deg_q * 4'd10 + byte_i[3:0]);
                end else begin
                  lon_min_d = mupd.acc;
                  fds_d     = mupd.fds;
                end
              end
              FLD_EW: begin
                west_d = (pos_q == 4'd0) && (byte_i == CH_WEST);
              end
              default: begin
              end
            endcase
            pos_d = sat_inc(pos_q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q <= 1'b0;
      type_ok_q <= 1'b0;
      field_q   <= '0;
      pos_q     <= '0;
      lat_deg_q <= '0;
      lat_min_q <= '0;
      lon_deg_q <= '0;
      lon_min_q <= '0;
      fds_q     <= '0;
      south_q   <= 1'b0;
      west_q    <= 1'b0;
      fix_q     <= 1'b0;
      xor_q     <= '0;
      rsum_q    <= '0;
      star_q    <= 1'b0;
    end else begin
      in_sent_q <= in_sent_d;
      type_ok_q <= type_ok_d;
      field_q   <= field_d;
      pos_q     <= pos_d;
      lat_deg_q <= lat_deg_d;
      lat_min_q <= lat_min_d;
      lon_deg_q <= lon_deg_d;
      lon_min_q <= lon_min_d;
      fds_q     <= fds_d;
      south_q   <= south_d;
      west_q    <= west_d;
      fix_q     <= fix_d;
      xor_q     <= xor_d;
      rsum_q    <= rsum_d;
      star_q    <= star_d;
    end
  end

  // CR inside a sentence past the type field, type matched
  assign emit_o = accept_i && (byte_i == CH_CR) && in_sent_q && type_ok_q &&
                  (field_q != FLD_TYPE);

  assign snap_o.lat_deg      = lat_deg_q;
  assign snap_o.lat_min      = lat_min_q;
  assign snap_o.south        = south_q;
  assign snap_o.lon_deg      = lon_deg_q;
  assign snap_o.lon_min      = lon_min_q;
  assign snap_o.west         = west_q;
  assign snap_o.flags.fix    = fix_q;
  assign snap_o.flags.cks_ok = star_q && (pos_q == CKS_LEN) && (xor_q == rsum_q);

endmodule

>>> rtl/nrmc_coord_conv.sv
// ----------------------------------------------------------------------------
// nrmc_coord_conv: degrees + scaled minutes to signed 1e-7 degrees
// Four register stages: scale, divide-by-three partial products, quotient
// with saturation, then add, clamp and sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrmc_coord_conv import nrmc_pkg::*; #(
  parameter int          DEG_W = 7,
  parameter int          OUT_W = 31,
  parameter int unsigned LIMIT = 900000000
) (
  input  logic                    clk_i,
  input  stage_en_t               en_i,
  input  logic [DEG_W-1:0]        deg_i,
  input  logic [MIN_W-1:0]        min_i,
  input  logic                    neg_i,
  output logic signed [OUT_W-1:0] coord_o
);

  localparam int DT_W  = DEG_W + DEG_SCALE_W;
  localparam int MAG_W = ((DT_W > Q_W) ? DT_W : Q_W) + 1;
  localparam int PP_W  = Y_W + RECIP_HW;
  localparam int PS_W  = Y_W + RECIP_W;

  localparam logic [A_MUL_W-1:0] A_MUL_L = A_MUL_W'(A_MUL);
  localparam logic [X_W-1:0]     X_SAT   = X_W'((64'(LIMIT) + 64'd1) * 64'(DIV_D));
  localparam logic [Q_W-1:0]     Q_SAT   = Q_W'(64'(LIMIT) + 64'd1);
  localparam logic [MAG_W-1:0]   MAG_LIM = MAG_W'(LIMIT);
  localparam logic [RECIP_HW-1:0] R_HI   = DIV3_RECIP[RECIP_W-1:RECIP_HW];
  localparam logic [RECIP_HW-1:0] R_LO   = DIV3_RECIP[RECIP_HW-1:0];

  // stage 2
  logic [MIN_W+A_MUL_W-1:0] prod;
  logic [X_W-1:0]           x_d, x_q;
  logic [DT_W-1:0]          dt_d, dt2_q;
  logic                     neg2_q;
  // stage 3
  logic [Y_W-1:0]  y;
  logic [PP_W-1:0] pp_hi_q, pp_lo_q;
  logic            sat3_q, neg3_q;
  logic [DT_W-1:0] dt3_q;
  // stage 4
  logic [PS_W-1:0] psum;
  logic [Q_W-1:0]  q_d, q_q;
  logic [DT_W-1:0] dt4_q;
  logic            neg4_q;
  // stage 5
  logic [MAG_W-1:0] mag, lim;
  logic [OUT_W-1:0] coord_d;

  assign prod = min_i * A_MUL_L;
  assign x_d  = {prod, 1'b0} + X_W'(C_DIV);
  assign dt_d = deg_i * DEG_SCALE;

  assign y = x_q[DIV_K +: Y_W];

  assign psum = {pp_hi_q, {RECIP_HW{1'b0}}} + PS_W'(pp_lo_q);
  assign q_d  = sat3_q ? Q_SAT : psum[RECIP_SHIFT +: Q_W];

  assign mag     = MAG_W'(dt4_q) + MAG_W'(q_q);
  assign lim     = (mag > MAG_LIM) ? MAG_LIM : mag;
  assign coord_d = neg4_q ? OUT_W'(-lim) : OUT_W'(lim);

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      x_q    <= x_d;
      dt2_q  <= dt_d;
      neg2_q <= neg_i;
    end
    if (en_i.s3) begin
      pp_hi_q <= y * R_HI;
      pp_lo_q <= y * R_LO;
      sat3_q  <= (x_q >= X_SAT);
      dt3_q   <= dt2_q;
      neg3_q  <= neg2_q;
    end
    if (en_i.s4) begin
      q_q    <= q_d;
      dt4_q  <= dt3_q;
      neg4_q <= neg3_q;
    end
    if (en_i.s5) begin
      coord_o <= coord_d;
    end
  end

endmodule

>>> rtl/nmea_rmc_position_parser_top.sv
// ----------------------------------------------------------------------------
// nmea_rmc_position_parser_top: GPRMC sentence position parser
// Parses an NMEA byte stream and returns latitude/longitude in 1e-7 degrees
// with fix and checksum flags, one result per GPRMC sentence.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   rx      | in        | in_valid_i/in_stall_o | rx_byte_i
//   result  | out       | out_valid_o/out_stall_i | latitude_e7_o, longitude_e7_o,
//           |           |                       | has_fix_o, checksum_ok_o
//
// One byte is taken per cycle while in_stall_o is low. After the transfer of the
// CR that ends the sentence, a result moves through the snapshot register and
// the conversion stages (scale, divide-by-three, quotient, clamp) to the output
// register. Reset is asynchronous and active low; no clearing pass is needed.
// A stalled result holds the output stage; the pipeline compresses bubbles,
// and in_stall_o rises only when the snapshot register holds a result that
// cannot move.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmea_rmc_position_parser_top import nrmc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              rx_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [LAT_W-1:0] latitude_e7_o,
  output logic signed [LON_W-1:0] longitude_e7_o,
  output logic                    has_fix_o,
  output logic                    checksum_ok_o
);

  // Stage go signals: a stage loads when it is empty or its content moves on
  logic go1, go2, go3, go4, go5;
  logic accept;

  logic  emit;
  snap_t snap;

  // Stage 1: sentence snapshot taken at CR
  logic  s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  snap_t s1_q;

  // Flags ride along with the converter stages
  flags_t f2_q, f3_q, f4_q, fo_q;

  stage_en_t en;

  assign go5 = !out_v_q || !out_stall_i;
  assign go4 = !s4_v_q || go5;
  assign go3 = !s3_v_q || go4;
  assign go2 = !s2_v_q || go3;
  assign go1 = !s1_v_q || go2;

  assign in_stall_o = !go1;
  assign accept     = in_valid_i && go1;

  assign en.s2 = go2;
  assign en.s3 = go3;
  assign en.s4 = go4;
  assign en.s5 = go5;

  nrmc_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (rx_byte_i),
    .emit_o  (emit),
    .snap_o  (snap)
  );

  // Valid bits of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (go1) s1_v_q  <= accept && emit;
      if (go2) s2_v_q  <= s1_v_q;
      if (go3) s3_v_q  <= s2_v_q;
      if (go4) s4_v_q  <= s3_v_q;
      if (go5) out_v_q <= s4_v_q;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (go1) s1_q <= snap;
    if (go2) f2_q <= s1_q.flags;
    if (go3) f3_q <= f2_q;
    if (go4) f4_q <= f3_q;
    if (go5) fo_q <= f4_q;
  end

  nrmc_coord_conv #(
    .DEG_W(LAT_DEG_W),
    .OUT_W(LAT_W),
    .LIMIT(LAT_LIMIT)
  ) u_lat_conv (
    .clk_i  (clk_i),
    .en_i   (en),
    .deg_i  (s1_q.lat_deg),
    .min_i  (s1_q.lat_min),
    .neg_i  (s1_q.south),
    .coord_o(latitude_e7_o)
  );

  nrmc_coord_conv #(
    .DEG_W(LON_DEG_W),
    .OUT_W(LON_W),
    .LIMIT(LON_LIMIT)
  ) u_lon_conv (
    .clk_i  (clk_i),
    .en_i   (en),
    .deg_i  (s1_q.lon_deg),
    .min_i  (s1_q.lon_min),
    .neg_i  (s1_q.west),
    .coord_o(longitude_e7_o)
  );

  assign out_valid_o   = out_v_q;
  assign has_fix_o     = fo_q.fix;
  assign checksum_ok_o = fo_q.cks_ok;

`ifndef SYNTH
  // Input is held back only by a blocked snapshot
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_v_q)
    else $error("input stalled with empty snapshot stage");

  // Only a CR transfer can load a result into the snapshot stage
  a_emit_on_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && rx_byte_i != CH_CR) |=> !s1_v_q)
    else $error("result created by a byte other than CR");

  // Clamp keeps the latitude inside +-90 degrees
  a_lat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (latitude_e7_o <= 31'sd900000000 &&
                     latitude_e7_o >= -31'sd900000000))
    else $error("latitude outside clamp range");
`endif

endmodule
